/* design/arc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_pkg
// shared types, constants and base compare helpers for the allele reference
// check core
// ----------------------------------------------------------------------------
package arc_pkg;

	// longest allele accepted by the position check
	localparam int MAX_REF_LEN = 256;

	localparam int BASE_W   = 8;
	localparam int COORD_W  = 32;
	localparam int LEN_W    = 9;
	localparam int STATUS_W = 2;

	// tdata widths of the slave and master sides
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 8;

	// run status codes, ordered so that a larger code wins
	localparam logic [STATUS_W-1:0] ST_MATCH      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CONSISTENT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_REF    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_POS    = 2'd3;

	// ascii nucleotide codes
	localparam logic [BASE_W-1:0] CH_A = 8'h41;
	localparam logic [BASE_W-1:0] CH_B = 8'h42;
	localparam logic [BASE_W-1:0] CH_C = 8'h43;
	localparam logic [BASE_W-1:0] CH_D = 8'h44;
	localparam logic [BASE_W-1:0] CH_G = 8'h47;
	localparam logic [BASE_W-1:0] CH_H = 8'h48;
	localparam logic [BASE_W-1:0] CH_K = 8'h4B;
	localparam logic [BASE_W-1:0] CH_M = 8'h4D;
	localparam logic [BASE_W-1:0] CH_N = 8'h4E;
	localparam logic [BASE_W-1:0] CH_R = 8'h52;
	localparam logic [BASE_W-1:0] CH_S = 8'h53;
	localparam logic [BASE_W-1:0] CH_T = 8'h54;
	localparam logic [BASE_W-1:0] CH_V = 8'h56;
	localparam logic [BASE_W-1:0] CH_W = 8'h57;
	localparam logic [BASE_W-1:0] CH_Y = 8'h59;
	localparam logic [BASE_W-1:0] CH_LOW_A = 8'h61;
	localparam logic [BASE_W-1:0] CH_LOW_Z = 8'h7A;
	localparam logic [BASE_W-1:0] CASE_OFS = 8'h20;

	// one accepted item as held in the input stage
	typedef struct packed {
		logic [BASE_W-1:0]  user_base;
		logic [BASE_W-1:0]  genome_base;
		logic [COORD_W-1:0] chrom_start;
		logic [COORD_W-1:0] chrom_end;
		logic [COORD_W-1:0] position;
		logic [LEN_W-1:0]   ref_length;
		logic               last;
	} item_t;

	// x is an ambiguity code and y is compatible with it
	function automatic logic one_way(input logic [BASE_W-1:0] x,
			input logic [BASE_W-1:0] y);
		logic r;
		r = (x == CH_B && y != CH_A) || (x == CH_D && y != CH_C)
			|| (x == CH_H && y != CH_G) || (x == CH_V && y != CH_T)
			|| (x == CH_W && (y == CH_A || y == CH_T))
			|| (x == CH_S && (y == CH_C || y == CH_G))
			|| (x == CH_M && (y == CH_A || y == CH_C))
			|| (x == CH_K && (y == CH_G || y == CH_T))
			|| (x == CH_R && (y == CH_A || y == CH_G))
			|| (x == CH_Y && (y == CH_C || y == CH_T));
		return r;
	endfunction

	// classify one base pair
	function automatic logic [STATUS_W-1:0] compare_bases(
			input logic [BASE_W-1:0] user, input logic [BASE_W-1:0] genome);
		logic [BASE_W-1:0]   u;
		logic [STATUS_W-1:0] r;
		u = user;
		if (user >= CH_LOW_A && user <= CH_LOW_Z) begin
			u = user - CASE_OFS;
		end
		if (u == genome) begin
			r = ST_MATCH;
		end else if (u == CH_N || genome == CH_N || one_way(u, genome)
				|| one_way(genome, u)) begin
			r = ST_CONSISTENT;
		end else begin
			r = ST_BAD_REF;
		end
		return r;
	endfunction

endpackage

/* design/allele_reference_check_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allele_reference_check_core
// streaming iupac base-pair check of a user allele against the genome
// reference, with a position check on the first item of each run
// ----------------------------------------------------------------------------
//
// channel   | dir | payload
// ----------+-----+-----------------------------------------------------------
// s_axis    | in  | one base pair per transaction, tlast ends the allele run
// m_axis    | out | one run status per run, sent after the last transaction
//
// one item per cycle sustained while m_axis does not stall; an item is registered
// at the input stage and folded into the run status when it leaves it, so a run's
// status is registered into the m_axis output register when its last item leaves
// the input stage.
// arst_n clears all valid flags and the run state (status match, at run start).
// a stalled m_axis only holds back an item that ends a run; items inside a
// run keep flowing while an earlier status waits to be taken.
//
module allele_reference_check_core
	import arc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// slave side
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// user_base[7:0], genome_base[15:8], chrom_start[47:16], chrom_end[79:48],
	// position[111:80], ref_length[120:112], zero pad[127:121]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tlast,
	// master side
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// status[1:0], zero pad[7:2]
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// input stage
	logic                item_vld_s1;
	item_t               item_s1;

	// run state
	logic [STATUS_W-1:0] run_status_q;
	logic                at_start_q;

	// output register
	logic                out_vld_q;
	logic [STATUS_W-1:0] out_status_q;

	logic                out_free;
	logic                consume;
	logic [COORD_W-1:0]  offset;
	logic                pos_bad;
	logic [STATUS_W-1:0] base_st;
	logic [STATUS_W-1:0] cur_st;
	logic [STATUS_W-1:0] next_st;

	assign out_free = !out_vld_q || m_axis_tready;

	// a run-ending item needs a free output slot, any other item moves freely
	assign consume = item_vld_s1 && (!item_s1.last || out_free);

	assign s_axis_tready = !item_vld_s1 || consume;

	// position check, only used on the first item of a run
	always_comb begin
		offset  = item_s1.chrom_start + item_s1.position;
		pos_bad = (item_s1.ref_length > LEN_W'(MAX_REF_LEN))
			|| ((34'(offset) + 34'(item_s1.ref_length) + 34'd1)
				> 34'(item_s1.chrom_end));
	end

	// fold this item into the run status
	always_comb begin
		base_st = compare_bases(item_s1.user_base, item_s1.genome_base);
		if (at_start_q) begin
			cur_st = pos_bad ? ST_BAD_POS : ST_MATCH;
		end else begin
			cur_st = run_status_q;
		end
		next_st = cur_st;
		// invalid is sticky; a zero-length item carries no base
		if (cur_st < ST_BAD_REF && item_s1.ref_length != '0 && base_st > cur_st) begin
			next_st = base_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			item_vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.user_base   <= s_axis_tdata[7:0];
			item_s1.genome_base <= s_axis_tdata[15:8];
			item_s1.chrom_start <= s_axis_tdata[47:16];
			item_s1.chrom_end   <= s_axis_tdata[79:48];
			item_s1.position    <= s_axis_tdata[111:80];
			item_s1.ref_length  <= s_axis_tdata[120:112];
			item_s1.last        <= s_axis_tlast;
		end
	end

	// run state returns to reset values after the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_status_q <= ST_MATCH;
			at_start_q   <= 1'b1;
		end else if (consume) begin
			if (item_s1.last) begin
				run_status_q <= ST_MATCH;
				at_start_q   <= 1'b1;
			end else begin
				run_status_q <= next_st;
				at_start_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (consume && item_s1.last) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && item_s1.last) begin
			out_status_q <= next_st;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-STATUS_W){1'b0}}, out_status_q};

endmodule
